// ----- src/e2e3t_pkg.sv -----
package e2e3t_pkg;

   // One input word: either an EVT2 word or a request to flush the pending mask.
   typedef struct packed {
      logic        req_type;
      logic [31:0] evt2_word;
   } req_payload_type;

   // One output word: an EVT3 word and the marker for the final word of an input.
   typedef struct packed {
      logic [15:0] evt3_word;
      logic        last;
   } rsp_payload_type;

   // Number of EVT3 words one input can cause.
   localparam int unsigned SLOT_COUNT = 5;

   // Result words of one input, in output order, with an enable for each slot.
   typedef struct packed {
      logic [SLOT_COUNT-1:0]       enable;
      logic [SLOT_COUNT-1:0][15:0] word;
   } word_set_type;

   // EVT2 word types.
   localparam logic [3:0] EVT2_CD_OFF      = 4'h0;
   localparam logic [3:0] EVT2_CD_ON       = 4'h1;
   localparam logic [3:0] EVT2_TIME_HIGH   = 4'h8;
   localparam logic [3:0] EVT2_EXT_TRIGGER = 4'hA;

   // EVT3 word codes.
   localparam logic [3:0] CODE_ADDR_Y      = 4'h0;
   localparam logic [3:0] CODE_ADDR_X      = 4'h2;
   localparam logic [3:0] CODE_VECT_BASE_X = 4'h3;
   localparam logic [3:0] CODE_VECT_8      = 4'h5;
   localparam logic [3:0] CODE_TIME_LOW    = 4'h6;
   localparam logic [3:0] CODE_TIME_HIGH   = 4'h8;
   localparam logic [3:0] CODE_EXT_TRIG    = 4'hA;

endpackage

// ----- src/e2e3t_encoder.sv -----
module e2e3t_encoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  e2e3t_pkg::req_payload_type item,
   input  logic                       master_slave,
   output e2e3t_pkg::word_set_type    words
);
   import e2e3t_pkg::*;

   // Output slot order. A flush never coincides with the very first time-high
   // word, since a mask can only hold pixels once time output has started.
   localparam int unsigned SLOT_FLUSH_A = 0;
   localparam int unsigned SLOT_FLUSH_B = 1;
   localparam int unsigned SLOT_TIME_HI = 2;
   localparam int unsigned SLOT_TIME_LO = 3;
   localparam int unsigned SLOT_TAIL    = 4;

   logic [17:0] in_time_high_ff, in_time_high_in;
   logic        in_time_valid_ff, in_time_valid_in;
   logic        out_time_started_ff, out_time_started_in;
   logic [11:0] out_time_high_ff, out_time_high_in;
   logic [11:0] out_time_low_ff, out_time_low_in;
   logic [10:0] row_y_ff, row_y_in;
   logic        row_valid_ff, row_valid_in;
   logic        group_polarity_ff, group_polarity_in;
   logic        polarity_valid_ff, polarity_valid_in;
   logic [7:0]  block_x_base_ff, block_x_base_in;
   logic [7:0]  pixel_mask_ff, pixel_mask_in;

   logic [3:0]  word_type;
   logic        is_flush_req, is_pixel, is_trigger, is_time_high, is_timed;
   logic [11:0] time_hi, time_lo;
   logic [10:0] pix_x, pix_y;
   logic        pix_pol;
   logic        time_start, hi_change, lo_change, row_change, pol_change, block_change;
   logic        mask_single, do_flush;
   logic [2:0]  single_pos;

   always_comb begin
      word_type    = item.evt2_word[31:28];
      is_flush_req = item.req_type;
      is_pixel     = !item.req_type && in_time_valid_ff &&
                     (word_type == EVT2_CD_OFF || word_type == EVT2_CD_ON);
      is_trigger   = !item.req_type && in_time_valid_ff && (word_type == EVT2_EXT_TRIGGER);
      is_time_high = !item.req_type && (word_type == EVT2_TIME_HIGH);
      is_timed     = is_pixel || is_trigger;

      time_hi = in_time_high_ff[17:6];
      time_lo = {in_time_high_ff[5:0], item.evt2_word[27:22]};
      pix_x   = item.evt2_word[21:11];
      pix_y   = item.evt2_word[10:0];
      pix_pol = word_type[0];

      time_start   = is_timed && !out_time_started_ff;
      hi_change    = is_timed && out_time_started_ff && (time_hi != out_time_high_ff);
      lo_change    = is_timed && (time_lo != out_time_low_ff);
      row_change   = is_pixel && (!row_valid_ff || pix_y != row_y_ff);
      pol_change   = is_pixel && (!polarity_valid_ff || pix_pol != group_polarity_ff);
      block_change = is_pixel && (pix_x[10:3] != block_x_base_ff);

      mask_single = ((pixel_mask_ff & (pixel_mask_ff - 8'd1)) == 8'd0);
      do_flush    = (pixel_mask_ff != 8'd0) &&
                    (is_flush_req || hi_change || lo_change || row_change ||
                     pol_change || block_change);

      single_pos = 3'd7;
      for (int i = 6; i >= 0; i--) begin
         if (pixel_mask_ff[i]) begin
            single_pos = 3'(i);
         end
      end
   end

   always_comb begin
      words.enable[SLOT_FLUSH_A] = do_flush;
      words.enable[SLOT_FLUSH_B] = do_flush && !mask_single;
      words.enable[SLOT_TIME_HI] = time_start || hi_change;
      words.enable[SLOT_TIME_LO] = lo_change;
      words.enable[SLOT_TAIL]    = row_change || is_trigger;

      if (mask_single) begin
         words.word[SLOT_FLUSH_A] = {CODE_ADDR_X, group_polarity_ff, block_x_base_ff, single_pos};
      end else begin
         words.word[SLOT_FLUSH_A] = {CODE_VECT_BASE_X, group_polarity_ff, block_x_base_ff, 3'd0};
      end
      words.word[SLOT_FLUSH_B] = {CODE_VECT_8, 4'd0, pixel_mask_ff};
      words.word[SLOT_TIME_HI] = {CODE_TIME_HIGH, time_hi};
      words.word[SLOT_TIME_LO] = {CODE_TIME_LOW, time_lo};
      if (is_trigger) begin
         words.word[SLOT_TAIL] = {CODE_EXT_TRIG, item.evt2_word[11:8], 7'd0, item.evt2_word[0]};
      end else begin
         words.word[SLOT_TAIL] = {CODE_ADDR_Y, master_slave, pix_y};
      end
   end

   always_comb begin
      in_time_high_in     = in_time_high_ff;
      in_time_valid_in    = in_time_valid_ff;
      out_time_started_in = out_time_started_ff;
      out_time_high_in    = out_time_high_ff;
      out_time_low_in     = out_time_low_ff;
      row_y_in            = row_y_ff;
      row_valid_in        = row_valid_ff;
      group_polarity_in   = group_polarity_ff;
      polarity_valid_in   = polarity_valid_ff;
      block_x_base_in     = block_x_base_ff;
      pixel_mask_in       = pixel_mask_ff;
      if (advance) begin
         if (is_time_high) begin
            in_time_high_in  = item.evt2_word[17:0];
            in_time_valid_in = 1'b1;
         end
         if (is_timed) begin
            out_time_started_in = 1'b1;
            out_time_high_in    = time_hi;
            out_time_low_in     = time_lo;
         end
         if (do_flush) begin
            pixel_mask_in = 8'd0;
         end
         if (is_pixel) begin
            row_y_in          = pix_y;
            row_valid_in      = 1'b1;
            group_polarity_in = pix_pol;
            polarity_valid_in = 1'b1;
            block_x_base_in   = pix_x[10:3];
            pixel_mask_in     = (do_flush ? 8'd0 : pixel_mask_ff) | (8'd1 << pix_x[2:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_time_high_ff     <= '0;
         in_time_valid_ff    <= 1'b0;
         out_time_started_ff <= 1'b0;
         out_time_high_ff    <= '0;
         out_time_low_ff     <= '0;
         row_y_ff            <= '0;
         row_valid_ff        <= 1'b0;
         group_polarity_ff   <= 1'b0;
         polarity_valid_ff   <= 1'b0;
         block_x_base_ff     <= '0;
         pixel_mask_ff       <= '0;
      end else begin
         in_time_high_ff     <= in_time_high_in;
         in_time_valid_ff    <= in_time_valid_in;
         out_time_started_ff <= out_time_started_in;
         out_time_high_ff    <= out_time_high_in;
         out_time_low_ff     <= out_time_low_in;
         row_y_ff            <= row_y_in;
         row_valid_ff        <= row_valid_in;
         group_polarity_ff   <= group_polarity_in;
         polarity_valid_ff   <= polarity_valid_in;
         block_x_base_ff     <= block_x_base_in;
         pixel_mask_ff       <= pixel_mask_in;
      end
   end

endmodule

// ----- src/e2e3t_drain.sv -----
module e2e3t_drain (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  e2e3t_pkg::word_set_type    words,
   output logic                       load_ok,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output e2e3t_pkg::rsp_payload_type rsp_data
);
   import e2e3t_pkg::*;

   logic [SLOT_COUNT-1:0]       pend_ff, pend_in;
   logic [SLOT_COUNT-1:0][15:0] word_ff, word_in;
   logic [SLOT_COUNT-1:0]       sel;
   logic [SLOT_COUNT-1:0]       remaining;
   logic [15:0]                 word_mux;

   always_comb begin
      // Lowest pending slot goes out first.
      sel      = pend_ff & (~pend_ff + SLOT_COUNT'(1));
      word_mux = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         word_mux = word_mux | (word_ff[i] & {16{sel[i]}});
      end
      rsp_valid          = (pend_ff != '0);
      rsp_data.evt3_word = word_mux;
      rsp_data.last      = ((pend_ff & ~sel) == '0);
      remaining          = (rsp_valid && rsp_ready) ? (pend_ff & ~sel) : pend_ff;
      load_ok            = (remaining == '0);
      pend_in            = advance ? words.enable : remaining;
      word_in            = advance ? words.word : word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

// ----- src/evt2_to_evt3_event_transcoder.sv -----
// Channel    Direction  Handshake              Content
// req_       in         req_valid/req_ready    req_type, evt2_word (one word)
// rsp_       out        rsp_valid/rsp_ready    evt3_word, last (one word)
// csr_       in         csr_write_en           master_slave, written without wait
//
// An accepted word lands in an input register and moves to the output buffer
// once the buffer can take all of its results; there its first EVT3 word is shown.
// The output buffer sends one word per cycle while rsp_ready is high and takes
// the next input as its last word leaves, so inputs with zero or one result
// flow at one word per cycle.
// Reset is synchronous and empties both registers and clears all decode state.
// A stall on rsp_ready holds the buffer and then the input register.
module evt2_to_evt3_event_transcoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  e2e3t_pkg::req_payload_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output e2e3t_pkg::rsp_payload_type rsp_data,
   input  logic                       csr_write_en,
   input  logic                       csr_write_data
);
   import e2e3t_pkg::*;

   // Input register: holds one word until the output buffer can take all of
   // its results.
   logic            item_valid_ff, item_valid_in;
   req_payload_type item_ff, item_in;
   // System type bit placed in every row word.
   logic            master_slave_ff, master_slave_in;

   logic            load_ok;
   logic            advance;
   word_set_type    words;

   always_comb begin
      // The word in the input register is decoded and moved whenever the output
      // buffer is empty or is sending its final word in this cycle.
      advance         = item_valid_ff && load_ok;
      req_ready       = !item_valid_ff || advance;
      item_valid_in   = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : item_valid_ff);
      item_in         = (req_valid && req_ready) ? req_data : item_ff;
      master_slave_in = csr_write_en ? csr_write_data : master_slave_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         master_slave_ff <= 1'b0;
      end else begin
         item_valid_ff   <= item_valid_in;
         master_slave_ff <= master_slave_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // Decoder and encoder state; builds the ordered set of result words.
   e2e3t_encoder u_encoder (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (item_ff),
      .master_slave (master_slave_ff),
      .words        (words)
   );

   // Output buffer; sends the enabled words one per cycle while rsp_ready is high.
   e2e3t_drain u_drain (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .words     (words),
      .load_ok   (load_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- src/e2e3t_checker.sv -----
module e2e3t_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input e2e3t_pkg::rsp_payload_type rsp_data
);
   import e2e3t_pkg::*;

   logic [3:0] code;
   assign code = rsp_data.evt3_word[15:12];

   // Nothing is shown in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output word shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled output word changed");

   // A word that is not the last of its input is always followed by another.
   a_not_last_more: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=> rsp_valid)
      else $error("word sequence broke off before its last word");

   // A vector base word is always followed by its vector word.
   a_vector_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && code == CODE_VECT_BASE_X |=>
      rsp_valid && rsp_data.evt3_word[15:12] == CODE_VECT_8)
      else $error("vector base word without vector word");

   a_known_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> code == CODE_ADDR_Y || code == CODE_ADDR_X ||
                    code == CODE_VECT_BASE_X || code == CODE_VECT_8 ||
                    code == CODE_TIME_LOW || code == CODE_TIME_HIGH ||
                    code == CODE_EXT_TRIG)
      else $error("output word with unexpected code");

endmodule

bind evt2_to_evt3_event_transcoder e2e3t_checker u_checker (.*);
